// ===== hw/rtl/gcm_pkg.sv =====
// Shared constants and width helpers for the gap cluster moments block.
package gcm_pkg;

  localparam int INDEX_BITS_DEF = 20;
  localparam int COUNT_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // round a bit count up to whole bytes
  function automatic int byte_pad(input int n);
    return ((n + 7) / 8) * 8;
  endfunction

  // bits of one result beat before padding
  function automatic int res_bits(input int ib, input int cb, input int fb);
    return 3 * ib + 2 * cb + 2 * (ib + fb) + 1;
  endfunction

endpackage

// ===== hw/rtl/gap_cluster_moments.sv =====
// Gap clustering of sorted tick indices with per-cluster count, mean and rms.
//
// Sample indices arrive in ascending order on the s_ beat channel (opcode in
// s_tuser: 0 = sample, 1 = end of record). A sample within min_gap of the
// previous one joins the open cluster; a larger gap closes it and opens a new
// one; an end beat closes the open cluster and clears all state except
// min_gap. A sample below the previous one is dropped and answered with a
// reject beat (m_tuser = 1, index in the low field, all else zero). A
// joining sample with a nonzero offset runs a bit-serial offset-squared
// shift-add, one offset bit per step, ending early when the offset's
// remaining bits are zero; opening and ending an empty record need no
// further state, and rejecting goes straight to the output state. Closing
// a cluster runs three bit-serial units in turn: shift-add products, a
// setup state, a restoring divider pair stepping one quotient bit a cycle
// and a square root taking two radicand bits a cycle, then loads the output
// register. One item is in work at a time; a result waiting in the output
// register does not block the next input beat unless that beat itself
// produces a result.
module gap_cluster_moments #(
  parameter int INDEX_BITS = gcm_pkg::INDEX_BITS_DEF,
  parameter int COUNT_BITS = gcm_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = gcm_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // min_gap register write
  input  logic                  cfg_we,
  input  logic [INDEX_BITS-1:0] cfg_data,
  // input beats
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [gcm_pkg::byte_pad(INDEX_BITS)-1:0] s_tdata, // sample_index
  input  logic s_tuser,                                     // opcode
  // result beats
  output logic m_tvalid,
  input  logic m_tready,
  // cluster_count, cluster_low, cluster_high, mean_offset, rms_offset,
  // trunc_mean_index, cluster_number, overflow
  output logic [gcm_pkg::byte_pad(gcm_pkg::res_bits(INDEX_BITS, COUNT_BITS,
                                                    FRAC_BITS))-1:0] m_tdata,
  output logic m_tuser                                      // kind
);
  import gcm_pkg::*;

  localparam int IW    = INDEX_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int FB    = FRAC_BITS;
  localparam int FIXW  = IW + FB;
  localparam int S1W   = IW + CB;
  localparam int S2W   = 2 * IW + CB;
  localparam int AW    = 2 * IW + 2 * CB;
  localparam int NNW   = 2 * CB;
  localparam int MW    = S1W + FB;
  localparam int DFULL = AW + 2 * FB;
  localparam int NW    = (DFULL > 128) ? 128 : DFULL;
  localparam int VW    = (NW > 64) ? 64 : NW;
  localparam int VW2   = VW + (VW % 2);
  localparam int RW    = VW2 / 2;
  localparam int CW    = $clog2(NW + 1);
  localparam int RB    = res_bits(IW, CB, FB);
  localparam int OW    = byte_pad(RB);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQR   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_ROOT  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam logic [CB-1:0] CNT_MAX = '1;

  logic [2:0]    state;
  logic [IW-1:0] min_gap;
  // cluster state
  logic          opn;
  logic [IW-1:0] prev;
  logic [IW-1:0] first;
  logic [CB-1:0] tally;
  logic          sat;
  logic [S1W-1:0] s1;
  logic [S2W-1:0] s2;
  logic [CB-1:0] seq;
  // pending action after a result
  logic          rej;
  logic          pend_end;
  logic [IW-1:0] pend_idx;
  // offset-squared shift-add
  logic [2*IW-1:0] mc;
  logic [IW-1:0]   mp;
  // product shift-add
  logic [AW-1:0]  am_sh, acc_a, bm_sh, acc_b;
  logic [NNW-1:0] nm_sh, acc_n;
  logic [CB-1:0]  n_sh;
  logic [S1W-1:0] s1m;
  logic [CW-1:0]  cnt;
  // dividers
  logic [MW-1:0]  mnum;
  logic [CB-1:0]  mrem;
  logic [NW-1:0]  vnum;
  logic [NNW-1:0] vrem;
  // square root
  logic [VW2-1:0] sx;
  logic [RW-1:0]  root;
  logic [RW:0]    rrem;

  logic [IW-1:0] idx, off, gap;
  logic [CB-1:0] nval;
  logic          accept;

  logic [CB:0]    mext;
  logic           mbit;
  logic [MW-1:0]  mnum_next;
  logic [CB-1:0]  mrem_next;
  logic [NNW:0]   vext;
  logic           vbit;
  logic [NW-1:0]  vnum_next;
  logic [NNW-1:0] vrem_next;
  logic [63:0]    vlo_next;
  logic [AW-1:0]  dval;
  logic [DFULL-1:0] dsh;
  logic [RW+1:0]  rx, trial;
  logic           vsat;
  logic [FIXW-1:0] mean_q, rms_q;
  logic [RB-1:0]  res_raw;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign idx      = s_tdata[IW-1:0];
  assign off      = idx - first;
  assign gap      = idx - prev;
  assign nval     = (tally == '0) ? CB'(1) : tally;

  // one quotient bit per divider per cycle
  always_comb begin
    mext      = {mrem, mnum[MW-1]};
    mbit      = (mext >= {1'b0, nval});
    mrem_next = mbit ? CB'(mext - {1'b0, nval}) : CB'(mext);
    mnum_next = {mnum[MW-2:0], mbit};
    vext      = {vrem, vnum[NW-1]};
    vbit      = (vext >= {1'b0, acc_n});
    vrem_next = vbit ? NNW'(vext - {1'b0, acc_n}) : NNW'(vext);
    vnum_next = {vnum[NW-2:0], vbit};
    vlo_next  = 64'(vnum_next);
  end

  always_comb begin
    dval = (acc_a >= acc_b) ? (acc_a - acc_b) : '0;
    dsh  = DFULL'(dval) << (2 * FB);
  end

  // square root: two radicand bits per cycle
  always_comb begin
    rx    = {rrem[RW-1:0], sx[VW2-1 -: 2]};
    trial = (RW + 2)'({root, 2'b01});
  end

  // quotient beyond 64 bits forces the rms to all ones
  assign vsat    = (NW > 64) ? (|(vnum >> 64)) : 1'b0;
  assign mean_q  = FIXW'(mnum);
  assign rms_q   = vsat ? '1 : FIXW'(root);
  assign res_raw = {sat, seq, first + IW'(mean_q >> FB), rms_q, mean_q,
                    prev, first, tally};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      min_gap  <= '0;
      m_tvalid <= 1'b0;
      opn      <= 1'b0;
      prev     <= '0;
      first    <= '0;
      tally    <= '0;
      sat      <= 1'b0;
      s1       <= '0;
      s2       <= '0;
      seq      <= '0;
      rej      <= 1'b0;
      pend_end <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_gap <= cfg_data;
      end
      // the output state reloads the register itself
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority if (s_tuser) begin
              if (opn) begin
                rej      <= 1'b0;
                pend_end <= 1'b1;
                state    <= ST_MUL;
              end else begin
                seq <= '0;
              end
            end else if (!opn) begin
              opn   <= 1'b1;
              prev  <= idx;
              first <= idx;
              tally <= CB'(1);
              s1    <= '0;
              s2    <= '0;
              sat   <= 1'b0;
            end else if (idx < prev) begin
              rej      <= 1'b1;
              pend_idx <= idx;
              state    <= ST_OUT;
            end else if (gap > min_gap) begin
              rej      <= 1'b0;
              pend_end <= 1'b0;
              pend_idx <= idx;
              state    <= ST_MUL;
            end else begin
              prev <= idx;
              if (tally == CNT_MAX) begin
                sat <= 1'b1;
              end else begin
                tally <= tally + CB'(1);
                s1    <= s1 + S1W'(off);
                mc    <= (2 * IW)'(off);
                mp    <= off;
                if (tally + CB'(1) == CNT_MAX) begin
                  sat <= 1'b1;
                end
                if (off != '0) begin
                  state <= ST_SQR;
                end
              end
            end
            // operands for the closing products
            am_sh <= AW'(s2);
            bm_sh <= AW'(s1);
            nm_sh <= NNW'(nval);
            n_sh  <= nval;
            s1m   <= s1;
            acc_a <= '0;
            acc_b <= '0;
            acc_n <= '0;
            cnt   <= '0;
          end
        end
        ST_SQR: begin
          if (mp[0]) begin
            s2 <= s2 + S2W'(mc);
          end
          mc <= mc << 1;
          mp <= mp >> 1;
          if (mp[IW-1:1] == '0) begin
            state <= ST_IDLE;
          end
        end
        ST_MUL: begin
          if (n_sh[0]) begin
            acc_a <= acc_a + am_sh;
            acc_n <= acc_n + nm_sh;
          end
          if (s1m[0]) begin
            acc_b <= acc_b + bm_sh;
          end
          am_sh <= am_sh << 1;
          bm_sh <= bm_sh << 1;
          nm_sh <= nm_sh << 1;
          n_sh  <= n_sh >> 1;
          s1m   <= s1m >> 1;
          cnt   <= cnt + CW'(1);
          if (cnt == CW'(S1W - 1)) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          vnum  <= NW'(dsh);
          vrem  <= '0;
          mnum  <= MW'(s1) << FB;
          mrem  <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          vnum <= vnum_next;
          vrem <= vrem_next;
          if (cnt < CW'(MW)) begin
            mnum <= mnum_next;
            mrem <= mrem_next;
          end
          if (cnt == CW'(NW - 1)) begin
            sx    <= VW2'(vlo_next);
            root  <= '0;
            rrem  <= '0;
            cnt   <= '0;
            state <= ST_ROOT;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_ROOT: begin
          if (rx >= trial) begin
            rrem <= (RW + 1)'(rx - trial);
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rrem <= (RW + 1)'(rx);
            root <= {root[RW-2:0], 1'b0};
          end
          sx  <= sx << 2;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(RW - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= rej;
            if (rej) begin
              m_tdata <= OW'({pend_idx, CB'(0)});
            end else begin
              m_tdata <= OW'(res_raw);
              if (pend_end) begin
                opn   <= 1'b0;
                prev  <= '0;
                first <= '0;
                tally <= '0;
                s1    <= '0;
                s2    <= '0;
                sat   <= 1'b0;
                seq   <= '0;
              end else begin
                seq   <= seq + CB'(1);
                prev  <= pend_idx;
                first <= pend_idx;
                tally <= CB'(1);
                s1    <= '0;
                s2    <= '0;
                sat   <= 1'b0;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gcm_check.sv =====
// Port-level checks for the gap cluster moments block, bound to its top level.
module gcm_check #(
  parameter int INDEX_BITS = gcm_pkg::INDEX_BITS_DEF,
  parameter int COUNT_BITS = gcm_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = gcm_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [gcm_pkg::byte_pad(gcm_pkg::res_bits(INDEX_BITS, COUNT_BITS,
                                                   FRAC_BITS))-1:0] m_tdata,
  input logic m_tuser
);
  import gcm_pkg::*;

  localparam int IW   = INDEX_BITS;
  localparam int CB   = COUNT_BITS;
  localparam int FIXW = INDEX_BITS + FRAC_BITS;
  localparam int LO   = CB;
  localparam int HI   = CB + IW;
  localparam int MO   = CB + 2 * IW;
  localparam int OV   = CB + 3 * IW + 2 * FIXW + CB;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[CB-1:0] == '0 && m_tdata[OV:HI] == '0)
    else $error("reject beat carries nonzero fields");

  a_report_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[CB-1:0] != '0 &&
      m_tdata[MO-1:HI] >= m_tdata[HI-1:LO])
    else $error("cluster report with empty count or high below low");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && m_tdata[OV] |-> m_tdata[CB-1:0] == '1)
    else $error("overflow flag without saturated count");

endmodule

bind gap_cluster_moments gcm_check #(
  .INDEX_BITS(INDEX_BITS),
  .COUNT_BITS(COUNT_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_gcm_check (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
